>>> rtl/core/mfmd_pkg.sv
// Shared constants and types for the multi-turn motor feedback decoder.
// No dependencies; imported by every module under rtl/core.
package mfmd_pkg;

	// Encoder and turn tracking
	localparam int TURN_COUNTS    = 8192;
	localparam int WRAP_THRESHOLD = 4000;

	// Filter coefficient format (Q0.16, one extra bit for unity)
	localparam int COEF_W = 17;
	localparam logic [COEF_W-1:0] COEF_ONE   = 17'd65536;
	localparam logic [COEF_W-1:0] COEF_RESET = 17'd32768;

	// Degrees per count scaled to Q.10: 360/8192 * 1024
	localparam int DEG_SCALE = 45;

	// Configuration register map
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_COEF   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CURRENT_COEF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_ANGLE = 2'd2;

	typedef logic [COEF_W-1:0] coef_t;
	typedef logic signed [31:0] q8_t;

endpackage

>>> rtl/core/mfmd_turn_tracker.sv
// Turn tracker: last angle, sticky start flag and wrapping turn count.
// Depends on mfmd_pkg.
module mfmd_turn_tracker import mfmd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [15:0]        mech,
	output logic signed [15:0] turns_next
);

	logic [15:0]        last_q;
	logic               started_q;
	logic signed [15:0] turns_q;
	logic signed [15:0] diff;
	logic signed [15:0] thr;
	logic               started_now;

	// Wrap detection on the 16-bit angle difference
	always_comb begin
		thr         = 16'(WRAP_THRESHOLD);
		diff        = $signed(16'(mech - last_q));
		started_now = started_q | (last_q != 16'd0);
		turns_next  = turns_q;
		if (started_now) begin
			if (diff > thr) begin
				turns_next = 16'(turns_q - 16'sd1);
			end else if (diff < -thr) begin
				turns_next = 16'(turns_q + 16'sd1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= '0;
			started_q <= 1'b0;
			turns_q   <= '0;
		end else if (en) begin
			last_q    <= mech;
			started_q <= started_now;
			turns_q   <= turns_next;
		end
	end

	// Start flag is sticky
	a_started_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |=> started_q)
		else $error("start flag cleared");

	// At most one turn per frame
	a_turn_step: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> (turns_q == $past(turns_q)) || (turns_q == 16'($past(turns_q) + 16'sd1))
			|| (turns_q == 16'($past(turns_q) - 16'sd1)))
		else $error("turn count moved by more than one");

	// No turn counted before the block has started
	a_no_turn_unstarted: assert property (@(posedge clk) disable iff (!arst_n)
		!started_q && last_q == 16'd0 |-> turns_next == turns_q)
		else $error("turn counted before start");

endmodule

>>> rtl/core/mfmd_lowpass.sv
// First-order low-pass filter, state in Q.8, Q0.16 weight on the new sample.
// Depends on mfmd_pkg.
module mfmd_lowpass import mfmd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic signed [15:0] sample,
	input  coef_t              coef,
	output q8_t                state
);

	q8_t                state_q;
	coef_t              c_sat;
	logic signed [32:0] delta;
	logic signed [50:0] prod;
	logic signed [34:0] sum;
	q8_t                state_next;

	// new = st + floor(c*(sample*256 - st) / 65536)
	always_comb begin
		c_sat      = (coef > COEF_ONE) ? COEF_ONE : coef;
		delta      = 33'($signed({sample, 8'd0})) - 33'(state_q);
		prod       = 51'(delta) * $signed({34'd0, c_sat});
		sum        = 35'(state_q) + prod[50:16];
		state_next = sum[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (en) begin
			state_q <= state_next;
		end
	end

	assign state = state_next;

endmodule

>>> rtl/core/motor_feedback_multiturn_decoder_core.sv
// Motor feedback multi-turn decoder, top level.
// Depends on mfmd_pkg, mfmd_turn_tracker and mfmd_lowpass.

// One request carries an 8-byte feedback frame; one result request leaves per frame,
// after passing the input register, the state update and degree scaling in turn.
// A new frame is taken every cycle while the result side keeps up; when the result
// is stalled the whole pipeline holds. Turn tracking and both filters update their
// state as a frame leaves the input register, so their feedback loops set the rate.
// Configuration writes are accepted at any time; the coefficients act
// on frames that reach the state update afterwards and the centre on frames that
// reach degree scaling afterwards, so write only while no frame is in flight.
module motor_feedback_multiturn_decoder_core import mfmd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [63:0]          payload,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [15:0]          mech_angle,
	output logic signed [15:0]   speed_raw,
	output logic signed [15:0]   current_raw,
	output logic [7:0]           driver_temp,
	output logic [7:0]           error_code,
	output logic signed [15:0]   turn_count,
	output logic signed [31:0]   total_angle,
	output logic signed [39:0]   angle_deg_q10,
	output logic signed [31:0]   speed_filtered,
	output logic signed [31:0]   current_filtered,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	coef_t              speed_coef_q;
	coef_t              current_coef_q;
	logic signed [31:0] center_q;

	logic               adv;
	logic               upd;
	logic               valid_s1, valid_s2, valid_s3;
	logic [63:0]        payload_s1;
	logic [63:0]        frame_s2, frame_s3;
	logic signed [15:0] turns_s2, turns_s3;
	logic signed [31:0] total_s2, total_s3;
	q8_t                spd_f_s2, spd_f_s3, cur_f_s2, cur_f_s3;
	logic signed [39:0] deg_s3;

	logic signed [15:0] turns_next;
	q8_t                spd_next, cur_next;
	logic signed [31:0] total_next;
	logic signed [39:0] delta40;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_coef_q   <= COEF_RESET;
			current_coef_q <= COEF_RESET;
			center_q       <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SPEED_COEF:   speed_coef_q   <= cfg_data[COEF_W-1:0];
				REG_CURRENT_COEF: current_coef_q <= cfg_data[COEF_W-1:0];
				REG_CENTER_ANGLE: center_q       <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// Whole pipeline moves together unless the result is stalled
	assign adv      = !valid_s3 || out_ready;
	assign in_ready = adv;
	assign upd      = adv && valid_s1;

	// State units
	mfmd_turn_tracker u_turns (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (upd),
		.mech       (payload_s1[63:48]),
		.turns_next (turns_next)
	);

	mfmd_lowpass u_speed_lp (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (upd),
		.sample ($signed(payload_s1[47:32])),
		.coef   (speed_coef_q),
		.state  (spd_next)
	);

	mfmd_lowpass u_current_lp (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (upd),
		.sample ($signed(payload_s1[31:16])),
		.coef   (current_coef_q),
		.state  (cur_next)
	);

	// Total angle, wraps mod 2^32
	assign total_next = $signed(32'(payload_s1[63:48])
		+ 32'(32'(turns_next) * 32'(TURN_COUNTS)));

	// Degrees from the 33-bit difference to the centre
	assign delta40 = 40'(total_s2) - 40'(center_q);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			if (in_valid) begin
				payload_s1 <= payload;
			end
			frame_s2 <= payload_s1;
			turns_s2 <= turns_next;
			total_s2 <= total_next;
			spd_f_s2 <= spd_next;
			cur_f_s2 <= cur_next;
			frame_s3 <= frame_s2;
			turns_s3 <= turns_s2;
			total_s3 <= total_s2;
			spd_f_s3 <= spd_f_s2;
			cur_f_s3 <= cur_f_s2;
			deg_s3   <= 40'(delta40 * 40'sd45);
		end
	end

	// Result ports
	assign out_valid        = valid_s3;
	assign mech_angle       = frame_s3[63:48];
	assign speed_raw        = $signed(frame_s3[47:32]);
	assign current_raw      = $signed(frame_s3[31:16]);
	assign driver_temp      = frame_s3[15:8];
	assign error_code       = frame_s3[7:0];
	assign turn_count       = turns_s3;
	assign total_angle      = total_s3;
	assign angle_deg_q10    = deg_s3;
	assign speed_filtered   = spd_f_s3;
	assign current_filtered = cur_f_s3;

	// Turns only add whole multiples of the turn size
	a_total_low_bits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> 32'(total_s3 - 32'(frame_s3[63:48])) % 32'(TURN_COUNTS) == 32'd0)
		else $error("total angle inconsistent with raw angle");

	// An empty result stage never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s3 |-> in_ready)
		else $error("input blocked with empty result stage");

	// A stalled result leaves the state units untouched
	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !out_ready |-> !upd)
		else $error("state updated during stall");

endmodule
